>>> hw/rtl/skt_pkg.sv
package skt_pkg;

  localparam int CMD_W    = 3;
  localparam int COORD_W  = 32;
  localparam int STATUS_W = 3;
  localparam int SPAN_W   = 6;
  localparam int CNT_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_MULT   = 3'd3,
    CMD_INSERT = 3'd4,
    CMD_REMOVE = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_ORDER = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_BELOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_t;

  typedef struct packed {
    logic lt;
    logic le;
    logic run_head;
  } skt_flags_t;

endpackage

>>> hw/rtl/sorted_knot_table_core.sv
// Channel | Direction | tdata                    | tuser
// in_     | slave     | coordinate [31:0]        | command [2:0]
// out_    | master    | span_index [5:0], multiplicity [12:6],
//         |           | knot_count [19:13], distinct_count [26:20] | status [2:0]
//
// An accepted command is registered and executes once the output register is free; its
// result is registered at the end of that cycle. One item per cycle sustained while
// out_tready stays high. The path is the broadcast compare across all knot cells and
// the two span count encoders. Reset clears the knot count and all handshake state;
// knot registers are not reset. A stalled output holds the pending command.
module sorted_knot_table_core import skt_pkg::*; #(
  parameter int MAX_KNOTS  = 64,
  parameter int KNOT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // coordinate [31:0]
  input  logic [CMD_W-1:0]    in_tuser,   // command [2:0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // span_index, multiplicity, knot_count,
                                          // distinct_count, zero pad [31:27]
  output logic [STATUS_W-1:0] out_tuser   // status [2:0]
);

  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam int SW = $clog2(MAX_KNOTS);
  localparam int N  = MAX_KNOTS;

  logic                  busy_r, busy_nxt;
  cmd_t                  cmd_r;
  logic [KNOT_WIDTH-1:0] key_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         dist_r, dist_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, status_nxt;
  logic [SPAN_W-1:0]     out_span_r;
  logic [CNT_W-1:0]      out_mult_r, out_cnt_r, out_dist_r;

  logic                  out_free, in_xfer, exec;
  logic signed [63:0]    coord_ext;
  logic [KNOT_WIDTH-1:0] in_key;

  logic [KNOT_WIDTH-1:0] knot [N];
  skt_flags_t            flg [N];
  cell_op_t              ops [N];
  logic [N-1:0]          lt_v, le_v, head_v, vld_v;
  logic [N-1:0]          le_shift, ins_mask, ins_prev, rem_mask, take_pos;
  logic [CW-1:0]         n_lt, n_le, mb, mult_nxt;
  logic [SW-1:0]         span_v, span_nxt;
  logic                  is_empty, is_full, eq_last, span_ok, uniq;
  logic                  do_ins, do_rem, use_lt;

  assign out_free  = !out_valid_r || out_tready;
  assign exec      = busy_r && out_free;
  assign in_tready = !busy_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  assign coord_ext = 64'(signed'(in_tdata));
  assign in_key    = coord_ext[KNOT_WIDTH-1:0] ^ {1'b1, {(KNOT_WIDTH-1){1'b0}}};

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [KNOT_WIDTH-1:0] left_k, right_k;
    if (i == 0) begin : g_head
      assign left_k = key_r;
    end else begin : g_mid
      assign left_k = knot[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right_k = knot[i];
    end else begin : g_body
      assign right_k = knot[i+1];
    end
    assign vld_v[i] = CW'(i) < count_r;

    skt_cell #(.KNOT_WIDTH(KNOT_WIDTH)) u_cell (
      .clk        (clk),
      .op         (ops[i]),
      .vld        (vld_v[i]),
      .has_left   (i != 0),
      .key        (key_r),
      .left_knot  (left_k),
      .right_knot (right_k),
      .knot       (knot[i]),
      .flags      (flg[i])
    );

    assign lt_v[i]   = flg[i].lt;
    assign le_v[i]   = flg[i].le;
    assign head_v[i] = flg[i].run_head;
  end

  skt_therm_count #(.MAX_KNOTS(N), .CW(CW)) u_cnt_lt (.therm(lt_v), .cnt(n_lt));
  skt_therm_count #(.MAX_KNOTS(N), .CW(CW)) u_cnt_le (.therm(le_v), .cnt(n_le));

  assign mb       = n_le - n_lt;
  assign is_empty = count_r == '0;
  assign is_full  = count_r == CW'(N);
  assign eq_last  = (n_le == count_r) && (n_lt != count_r);
  assign span_ok  = eq_last ? (n_lt != '0) : (n_le != '0);
  assign span_v   = eq_last ? SW'(n_lt - CW'(1)) : SW'(n_le - CW'(1));

  assign le_shift = {1'b0, le_v[N-1:1]};
  assign ins_mask = use_lt ? ~lt_v : ~le_v;
  assign ins_prev = {ins_mask[N-2:0], 1'b0};
  assign rem_mask = ~le_shift;
  assign take_pos = le_v & ~le_shift;
  assign uniq     = |(take_pos & head_v);

  always_comb begin
    status_nxt = ST_OK;
    span_nxt   = '0;
    mult_nxt   = mb;
    count_nxt  = count_r;
    dist_nxt   = dist_r;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    use_lt     = 1'b0;
    case (cmd_r)
      CMD_CLEAR: begin
        count_nxt = '0;
        dist_nxt  = '0;
        mult_nxt  = '0;
      end
      CMD_APPEND: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else if (!is_empty && (n_le != count_r)) begin
          status_nxt = ST_ORDER;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CW'(1);
          mult_nxt  = mb + CW'(1);
          if (mb == '0) dist_nxt = dist_r + CW'(1);
        end
      end
      CMD_FIND: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else if (!span_ok) begin
          status_nxt = ST_BELOW;
        end else begin
          span_nxt = span_v;
        end
      end
      CMD_INSERT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else if (is_full) begin
          status_nxt = ST_FULL;
        end else if (!span_ok) begin
          status_nxt = ST_BELOW;
        end else begin
          do_ins    = 1'b1;
          use_lt    = eq_last;
          span_nxt  = span_v;
          count_nxt = count_r + CW'(1);
          mult_nxt  = mb + CW'(1);
          if (mb == '0) dist_nxt = dist_r + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else if (eq_last) begin
          span_nxt  = span_ok ? span_v : '0;
          count_nxt = count_r - CW'(1);
          mult_nxt  = mb - CW'(1);
          if (mb == CW'(1)) dist_nxt = dist_r - CW'(1);
        end else if (!span_ok) begin
          status_nxt = ST_BELOW;
        end else begin
          do_rem    = 1'b1;
          span_nxt  = span_v;
          count_nxt = count_r - CW'(1);
          if (mb != '0) begin
            mult_nxt = mb - CW'(1);
            if (mb == CW'(1)) dist_nxt = dist_r - CW'(1);
          end else if (uniq) begin
            dist_nxt = dist_r - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ops[i] = CELL_HOLD;
      if (exec && do_ins && ins_mask[i]) begin
        ops[i] = ins_prev[i] ? CELL_LEFT : CELL_LOAD;
      end else if (exec && do_rem && rem_mask[i]) begin
        ops[i] = CELL_RIGHT;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end else if (exec) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      dist_r      <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        count_r <= count_nxt;
        dist_r  <= dist_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= cmd_t'(in_tuser);
      key_r <= in_key;
    end
    if (exec) begin
      out_status_r <= status_nxt;
      out_span_r   <= SPAN_W'(span_nxt);
      out_mult_r   <= CNT_W'(mult_nxt);
      out_cnt_r    <= CNT_W'(count_nxt);
      out_dist_r   <= CNT_W'(dist_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'b0, out_dist_r, out_cnt_r, out_mult_r, out_span_r};

endmodule

>>> hw/rtl/skt_cell.sv
module skt_cell import skt_pkg::*; #(
  parameter int KNOT_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic                  vld,
  input  logic                  has_left,
  input  logic [KNOT_WIDTH-1:0] key,
  input  logic [KNOT_WIDTH-1:0] left_knot,
  input  logic [KNOT_WIDTH-1:0] right_knot,
  output logic [KNOT_WIDTH-1:0] knot,
  output skt_flags_t            flags
);

  logic [KNOT_WIDTH-1:0] knot_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:  knot_r <= key;
      CELL_LEFT:  knot_r <= left_knot;
      CELL_RIGHT: knot_r <= right_knot;
      default:    knot_r <= knot_r;
    endcase
  end

  assign knot           = knot_r;
  assign flags.lt       = vld && (knot_r < key);
  assign flags.le       = vld && (knot_r <= key);
  assign flags.run_head = !has_left || (knot_r != left_knot);

endmodule

>>> hw/rtl/skt_therm_count.sv
module skt_therm_count #(
  parameter int MAX_KNOTS = 64,
  parameter int CW        = 7
) (
  input  logic [MAX_KNOTS-1:0] therm,
  output logic [CW-1:0]        cnt
);

  logic [MAX_KNOTS-1:0] edge_v;
  logic [CW-1:0]        acc;

  always_comb begin
    acc = '0;
    for (int i = 0; i < MAX_KNOTS; i++) begin
      if (i == 0) begin
        edge_v[i] = !therm[i];
      end else begin
        edge_v[i] = !therm[i] && therm[i-1];
      end
      if (edge_v[i]) begin
        acc = acc | CW'(i);
      end
    end
    cnt = (&therm) ? CW'(MAX_KNOTS) : acc;
  end

endmodule
